### rtl/b64_pkg.sv
// Shared types, constants and alphabet functions for the Base64 stream codec.
// No dependencies.
package b64_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
  localparam logic [7:0] CharUpperZ = 8'h5A;  // 'Z'
  localparam logic [7:0] CharLowerA = 8'h61;  // 'a'
  localparam logic [7:0] CharLowerZ = 8'h7A;  // 'z'
  localparam logic [7:0] CharZero   = 8'h30;  // '0'
  localparam logic [7:0] CharNine   = 8'h39;  // '9'
  localparam logic [7:0] CharPlus   = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash  = 8'h2F;  // '/'
  localparam logic [7:0] CharPad    = 8'h3D;  // '='
  localparam logic [5:0] LetterCnt  = 6'd26;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    OP_ENC = 2'd0,
    OP_DEC = 2'd1,
    OP_ERR = 2'd2
  } op_e;

  // One group of work handed from front to back.
  typedef struct packed {
    op_e         op;
    logic [23:0] bits;
    logic [2:0]  n_chars;  // encode: alphabet chars before padding
    logic        last;
  } job_t;

  function automatic logic [7:0] sextet_to_char(logic [5:0] v);
    logic [7:0] c;
    if (v < LetterCnt) begin
      c = 8'(CharUpperA + {2'b00, v});
    end else if (v < 6'd52) begin
      c = 8'(CharLowerA + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      c = 8'(CharZero + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

  function automatic logic [5:0] char_to_sextet(logic [7:0] c);
    logic [5:0] v;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      v = 6'(c - CharUpperA);
    end else if (c >= CharLowerA && c <= CharLowerZ) begin
      v = 6'(c - CharLowerA + 8'd26);
    end else if (c >= CharZero && c <= CharNine) begin
      v = 6'(c - CharZero + 8'd52);
    end else if (c == CharPlus) begin
      v = 6'd62;
    end else if (c == CharSlash) begin
      v = 6'd63;
    end else begin
      v = 6'd0;
    end
    return v;
  endfunction

endpackage

### rtl/b64_front.sv
// Front end: mode register, input request acceptance and group gathering.
// Emits one job per full group or group cut short by in_last_i. Depends on b64_pkg.
module b64_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_mode_i,
  input  logic             in_acc_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             push_o,
  output b64_pkg::job_t    job_o
);

  b64_pkg::mode_e mode_q, mode_d;
  logic [23:0]    group_bits_q, group_bits_d;
  logic [1:0]     group_count_q, group_count_d;
  logic [2:0]     cnt;
  logic [23:0]    enc_bits;
  logic [23:0]    dec_bits;

  always_comb begin
    cnt      = {1'b0, group_count_q} + 3'd1;
    enc_bits = {group_bits_q[15:0], in_byte_i};
    dec_bits = {group_bits_q[17:0], b64_pkg::char_to_sextet(in_byte_i)};

    mode_d        = mode_q;
    group_bits_d  = group_bits_q;
    group_count_d = group_count_q;
    push_o        = 1'b0;
    job_o.op      = b64_pkg::OP_ENC;
    job_o.bits    = enc_bits;
    job_o.n_chars = 3'd4;
    job_o.last    = in_last_i;

    if (cfg_valid_i) begin
      mode_d        = b64_pkg::mode_e'(cfg_mode_i);
      group_bits_d  = '0;
      group_count_d = '0;
    end else if (in_acc_i) begin
      if (mode_q == b64_pkg::MODE_ENCODE) begin
        if (cnt >= 3'd3) begin
          push_o        = 1'b1;
          group_bits_d  = '0;
          group_count_d = '0;
        end else if (!in_last_i) begin
          group_bits_d  = enc_bits;
          group_count_d = cnt[1:0];
        end else begin
          push_o        = 1'b1;
          job_o.bits    = (cnt == 3'd1) ? {enc_bits[7:0], 16'h0000}
                                        : {enc_bits[15:0], 8'h00};
          job_o.n_chars = 3'(cnt + 3'd1);
          group_bits_d  = '0;
          group_count_d = '0;
        end
      end else begin
        job_o.bits = dec_bits;
        if (cnt == 3'd4) begin
          push_o        = 1'b1;
          job_o.op      = b64_pkg::OP_DEC;
          group_bits_d  = '0;
          group_count_d = '0;
        end else if (in_last_i) begin
          push_o        = 1'b1;
          job_o.op      = b64_pkg::OP_ERR;
          group_bits_d  = '0;
          group_count_d = '0;
        end else begin
          group_bits_d  = dec_bits;
          group_count_d = cnt[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= b64_pkg::MODE_ENCODE;
      group_bits_q  <= '0;
      group_count_q <= '0;
    end else begin
      mode_q        <= mode_d;
      group_bits_q  <= group_bits_d;
      group_count_q <= group_count_d;
    end
  end

endmodule

### rtl/b64_fifo.sv
// Small job queue between front and back ends, register based.
// Depends on b64_pkg.
module b64_fifo #(
  parameter int unsigned Depth = b64_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64_pkg::job_t  push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output b64_pkg::job_t  pop_data_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/b64_back.sv
// Back end: takes jobs from the queue and serializes them into result
// requests through an output register. Depends on b64_pkg.
module b64_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  b64_pkg::job_t  job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic           out_error_o
);

  b64_pkg::job_t job_q, job_d;
  logic          job_valid_q, job_valid_d;
  logic [1:0]    idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  logic          out_error_q, out_error_d;
  logic [1:0]    final_idx;
  logic          is_final;
  logic          emit;
  logic          load;
  logic [5:0]    sextet;
  logic [7:0]    dec_byte;

  always_comb begin
    unique case (idx_q)
      2'd0: begin sextet = job_q.bits[23:18]; dec_byte = job_q.bits[23:16]; end
      2'd1: begin sextet = job_q.bits[17:12]; dec_byte = job_q.bits[15:8];  end
      2'd2: begin sextet = job_q.bits[11:6];  dec_byte = job_q.bits[7:0];   end
      default: begin sextet = job_q.bits[5:0]; dec_byte = job_q.bits[7:0]; end
    endcase

    unique case (job_q.op)
      b64_pkg::OP_ENC: final_idx = 2'd3;
      b64_pkg::OP_DEC: final_idx = 2'd2;
      default:         final_idx = 2'd0;
    endcase

    is_final = (idx_q == final_idx);
    emit     = job_valid_q && (!out_valid_q || !out_stall_i);
    load     = !empty_i && (!job_valid_q || (emit && is_final));
    pop_o    = load;

    job_d       = load ? job_i : job_q;
    job_valid_d = load ? 1'b1 : ((emit && is_final) ? 1'b0 : job_valid_q);
    idx_d       = load ? 2'd0 : (emit ? 2'(idx_q + 2'd1) : idx_q);

    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_error_d = out_error_q;
    if (emit) begin
      out_valid_d = 1'b1;
      unique case (job_q.op)
        b64_pkg::OP_ENC: begin
          out_byte_d  = ({1'b0, idx_q} < job_q.n_chars)
                        ? b64_pkg::sextet_to_char(sextet) : b64_pkg::CharPad;
          out_last_d  = job_q.last && is_final;
          out_error_d = 1'b0;
        end
        b64_pkg::OP_DEC: begin
          out_byte_d  = dec_byte;
          out_last_d  = job_q.last && is_final;
          out_error_d = 1'b0;
        end
        default: begin
          out_byte_d  = 8'h00;
          out_last_d  = 1'b1;
          out_error_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_error_q <= out_error_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_error_o = out_error_q;

endmodule

### rtl/base64_stream_codec_core.sv
// Top level of the streaming Base64 codec: front end, job queue, back end.
// Depends on b64_pkg, b64_front, b64_fifo, b64_back.
//
// Streaming RFC 4648 Base64 codec. cfg_mode_i = 0 encodes bytes into alphabet
// characters (groups of three bytes give four characters; a last byte that
// closes a short group gives '='-padded output), 1 decodes characters into
// bytes (four characters give three bytes; characters outside the alphabet
// and '=' count as zero; a last character that leaves a group incomplete
// gives a single result with out_error_o set). A mode write clears any
// partial group and may only be issued while the codec is idle. The front
// end takes one input request per cycle unless the job queue is full; the
// back end sends one result per cycle through its output register unless
// the receiver stalls, so encoding throughput is set by that single result
// port (three bytes give four characters); decoding takes one input per
// cycle. A completed group passes through the job queue, the back end's job
// register and output register; results then follow one per unstalled cycle.
module base64_stream_codec_core #(
  parameter int unsigned QueueDepth = b64_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o,
  output logic       out_error_o
);

  b64_pkg::job_t push_job, head_job;
  logic          push, pop, full, empty, in_acc, cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = full;
  assign in_acc      = in_valid_i && !in_stall_o;

  b64_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_we),
    .cfg_mode_i (cfg_mode_i),
    .in_acc_i   (in_acc),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .push_o     (push),
    .job_o      (push_job)
  );

  b64_fifo #(
    .Depth(QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_job),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (head_job),
    .empty_o    (empty)
  );

  b64_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .out_error_o(out_error_o)
  );

`ifndef SYNTHESIS
  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_error_o |-> out_last_o && out_byte_o == 8'h00)
    else $error("error result not marked last with zero byte");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("back end pulled from empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("front end pushed into full queue");
`endif

endmodule

### bench/b64_codec_checker.sv
// Result checker for the Base64 stream codec: watches the mode, input and output
// channels, predicts every result and compares it field by field.
// Depends on b64_pkg for the mode type and the character constants.
module b64_codec_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic       cfg_mode_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  input  logic       out_error_i,
  output int         fail_cnt_o,
  output int         pending_o,
  output int         checked_o
);

  localparam string Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } codec_result_t;

  codec_result_t   expected_q[$];
  b64_pkg::mode_e  mode_q;
  logic [23:0]     group_bits_q;
  logic [1:0]      group_cnt_q;
  logic [5:0]      sextet_of[256];

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
    checked_o  = 0;
    for (int i = 0; i < 256; i++) sextet_of[i] = 6'd0;
    for (int i = 0; i < 64; i++) sextet_of[Alphabet[i]] = 6'(i);
  end

  function automatic logic [7:0] char_of(logic [5:0] v);
    return Alphabet[v];
  endfunction

  task automatic push_result(input logic [7:0] data, input logic last, input logic err);
    codec_result_t r;
    r.data = data;
    r.last = last;
    r.err  = err;
    expected_q.push_back(r);
  endtask

  task automatic take_symbol(input logic [7:0] sym, input logic last);
    logic [23:0] acc;
    logic [2:0]  n;
    n = {1'b0, group_cnt_q} + 3'd1;
    if (mode_q == b64_pkg::MODE_ENCODE) begin
      acc = {group_bits_q[15:0], sym};
      if (n == 3'd3) begin
        for (int k = 0; k < 4; k++)
          push_result(char_of(6'(acc >> (18 - 6 * k))), last && k == 3, 1'b0);
        group_bits_q = '0;
        group_cnt_q  = '0;
      end else if (!last) begin
        group_bits_q = acc;
        group_cnt_q  = n[1:0];
      end else begin
        // short final group: shift up to the top and pad with '='
        acc = acc << (8 * (3 - n));
        for (int k = 0; k < 4; k++)
          push_result((k <= n) ? char_of(6'(acc >> (18 - 6 * k))) : b64_pkg::CharPad,
                      k == 3, 1'b0);
        group_bits_q = '0;
        group_cnt_q  = '0;
      end
    end else begin
      acc = {group_bits_q[17:0], sextet_of[sym]};
      if (n == 3'd4) begin
        push_result(acc[23:16], 1'b0, 1'b0);
        push_result(acc[15:8], 1'b0, 1'b0);
        push_result(acc[7:0], last, 1'b0);
        group_bits_q = '0;
        group_cnt_q  = '0;
      end else if (last) begin
        push_result(8'h00, 1'b1, 1'b1);
        group_bits_q = '0;
        group_cnt_q  = '0;
      end else begin
        group_bits_q = acc;
        group_cnt_q  = n[1:0];
      end
    end
  endtask

  task automatic compare_result();
    codec_result_t r;
    if (expected_q.size() == 0) begin
      $error("out_byte: expected no result, actual %02h (last %0b error %0b)",
             out_byte_i, out_last_i, out_error_i);
      fail_cnt_o++;
    end else begin
      r = expected_q.pop_front();
      checked_o++;
      if (out_byte_i !== r.data) begin
        $error("out_byte: expected %02h, actual %02h", r.data, out_byte_i);
        fail_cnt_o++;
      end
      if (out_last_i !== r.last) begin
        $error("out_last: expected %0b, actual %0b", r.last, out_last_i);
        fail_cnt_o++;
      end
      if (out_error_i !== r.err) begin
        $error("out_error: expected %0b, actual %0b", r.err, out_error_i);
        fail_cnt_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       = b64_pkg::MODE_ENCODE;
      group_bits_q = '0;
      group_cnt_q  = '0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) compare_result();
      // a mode write drops any partial group
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q       = b64_pkg::mode_e'(cfg_mode_i);
        group_bits_q = '0;
        group_cnt_q  = '0;
      end
      if (in_valid_i && !in_stall_i) take_symbol(in_byte_i, in_last_i);
    end
    pending_o = expected_q.size();
  end

endmodule

### bench/base64_stream_codec_core_test.sv
// Testbench top for base64_stream_codec_core: clock, reset, mode writes and
// request stimulus under several idle/stall mixes. Depends on b64_pkg,
// b64_codec_checker and the codec RTL.
module base64_stream_codec_core_test;

  localparam int CycleLimit   = 100000;
  localparam int SettleCycles = 16;
  localparam int LongHold     = 300;
  localparam int BlockItems   = 50;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_mode;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  int fail_cnt;
  int pending;
  int checked;
  int cycle_cnt;
  int items_sent;
  int modes_written;
  int tx_idle_pct;
  int rx_stall_pct;
  logic long_hold_req;
  logic long_hold_done;

  base64_stream_codec_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_mode_i (cfg_mode),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_byte_i  (in_byte),
    .in_last_i  (in_last),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_byte_o (out_byte),
    .out_last_o (out_last),
    .out_error_o(out_error)
  );

  b64_codec_checker result_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_mode_i (cfg_mode),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_byte_i  (in_byte),
    .in_last_i  (in_last),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_byte_i (out_byte),
    .out_last_i (out_last),
    .out_error_i(out_error),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    out_stall      = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic send_symbol(input logic [7:0] sym, input logic last);
    in_valid <= 1'b1;
    in_byte  <= sym;
    in_last  <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input b64_pkg::mode_e m);
    cfg_valid <= 1'b1;
    cfg_mode  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    modes_written++;
  endtask

  task automatic send_raw_message(input int len);
    for (int k = 0; k < len; k++) send_symbol(8'($urandom_range(255)), k == len - 1);
  endtask

  // well-formed text: whole groups, optional '=' padding at the end
  task automatic send_text_message(input int groups, input int pad);
    logic [7:0] c;
    for (int k = 0; k < 4 * groups; k++) begin
      c = (k >= 4 * groups - pad) ? b64_pkg::CharPad
                                  : b64_pkg::sextet_to_char(6'($urandom_range(63)));
      send_symbol(c, k == 4 * groups - 1);
    end
  endtask

  task automatic run_block(input b64_pkg::mode_e m, input int count);
    int start;
    wait_idle();
    write_mode(m);
    start = items_sent;
    while (items_sent - start < count) begin
      if (m == b64_pkg::MODE_ENCODE) send_raw_message($urandom_range(1, 10));
      else if ($urandom_range(99) < 80)
        send_text_message($urandom_range(1, 3), $urandom_range(0, 2));
      else send_raw_message($urandom_range(1, 9));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_mode      = b64_pkg::MODE_ENCODE;
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    in_last       = 1'b0;
    items_sent    = 0;
    modes_written = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    long_hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // encode after reset: full group, one-byte and two-byte tails
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h80, 1'b1);
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'hFB, 1'b0);
    send_symbol(8'hFF, 1'b1);
    wait_idle();
    write_mode(b64_pkg::MODE_DECODE);
    // decode: top and bottom sextets, padding, characters outside the alphabet
    send_text_message(0, 0);
    for (int k = 0; k < 4; k++) send_symbol(b64_pkg::CharSlash, k == 3);
    for (int k = 0; k < 4; k++) send_symbol(b64_pkg::CharUpperA, k == 3);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h40, 1'b0);
    send_symbol(8'h7B, 1'b1);
    send_symbol(8'h51, 1'b0);
    send_symbol(8'h51, 1'b0);
    send_symbol(b64_pkg::CharPad, 1'b0);
    send_symbol(b64_pkg::CharPad, 1'b1);
    // length errors: one and three characters
    send_symbol(b64_pkg::CharPlus, 1'b1);
    send_symbol(b64_pkg::CharZero, 1'b0);
    send_symbol(b64_pkg::CharNine, 1'b0);
    send_symbol(b64_pkg::CharLowerZ, 1'b1);
    // partial group abandoned by a mode write
    send_symbol(b64_pkg::CharLowerA, 1'b0);
    send_symbol(b64_pkg::CharUpperZ, 1'b0);
    wait_idle();
    write_mode(b64_pkg::MODE_ENCODE);
    send_symbol(8'h01, 1'b1);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          long_hold_req <= 1'b1;
        end
        1: begin
          tx_idle_pct  = 57;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 57;
        end
        default: begin
          tx_idle_pct  = 21;
          rx_stall_pct = 21;
        end
      endcase
      run_block(b64_pkg::MODE_ENCODE, BlockItems);
      run_block(b64_pkg::MODE_DECODE, BlockItems);
    end

    wait_idle();
    $display("run covered %0d input requests and %0d mode writes over four idle/stall mixes",
             items_sent, modes_written);
    $display("%0d results compared field by field, %0d failures", checked, fail_cnt);
    if (fail_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
